// ===== src/ptps_pkg.sv =====
package ptps_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_GRAVITY    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DRAG       = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BOUNCE     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ALPHA_LIFE = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ALPHA_STEP = 3'd4;

  // request function codes
  localparam logic [1:0] FUNC_SPAWN     = 2'd0;
  localparam logic [1:0] FUNC_TICK      = 2'd1;
  localparam logic [1:0] FUNC_SET_COLOR = 2'd2;
  localparam logic [1:0] FUNC_READ      = 2'd3;

  localparam logic [15:0] FADE_LIFE  = 16'd80;
  localparam logic [7:0]  RED_FULL   = 8'd204;
  localparam logic [7:0]  GREEN_FULL = 8'd179;
  localparam logic [7:0]  BLUE_FULL  = 8'd51;

  typedef struct packed {
    logic [1:0]         func;
    logic [8:0]         slot_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        color_rgba;
    logic [30:0]        height_size;
    logic [15:0]        life_ticks;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [8:0]         result_slot;
    logic               slot_alive;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic [31:0]        out_color;
    logic [9:0]         live_count;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic               alive;
    logic [15:0]        life;
    logic [30:0]        height;
    logic [31:0]        color;
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } slot_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_SPAWN,
    MODE_TICK
  } mode_t;

  typedef struct packed {
    logic               take;
    logic               rd_en;
    logic               rd_item;
    mode_t              mode;
    logic               col_wr;
    logic               clr_en;
    logic               load_out;
    logic [SLOT_AW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic spawn_hit;
    logic rd_pend;
    logic tick_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== src/ptps_ctrl.sv =====
module ptps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_stall,
  output ptps_pkg::cmd_t cmd,
  input  ptps_pkg::sts_t sts
);
  import ptps_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAWN,
    ST_TICK,
    ST_READ,
    ST_COL_RD,
    ST_COL_WR,
    ST_DONE
  } state_t;

  localparam logic [CNT_W-1:0] NSLOT = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] LAST  = CNT_W'(SLOT_COUNT - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.mode = MODE_NONE;
    cmd.addr = cnt_r[SLOT_AW-1:0];
    unique case (state_r)
      ST_CLEAR:  cmd.clr_en = 1'b1;
      ST_IDLE:   cmd.take = in_valid;
      ST_SPAWN: begin
        cmd.mode  = MODE_SPAWN;
        cmd.rd_en = (cnt_r < NSLOT);
      end
      ST_TICK: begin
        cmd.mode  = MODE_TICK;
        cmd.rd_en = (cnt_r < NSLOT);
      end
      ST_READ, ST_COL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
      end
      ST_COL_WR: cmd.col_wr = 1'b1;
      ST_DONE:   cmd.load_out = sts.out_free;
      default:   cmd.mode = MODE_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          unique case (in_func)
            FUNC_SPAWN:     state_nxt = ST_SPAWN;
            FUNC_TICK:      state_nxt = ST_TICK;
            FUNC_SET_COLOR: state_nxt = ST_COL_RD;
            FUNC_READ:      state_nxt = ST_READ;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SPAWN: begin
        if (sts.spawn_hit) begin
          state_nxt = ST_DONE;
        end else if (cnt_r == NSLOT && !sts.rd_pend) begin
          state_nxt = ST_DONE;
        end else if (cnt_r < NSLOT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TICK: begin
        if (cnt_r < NSLOT) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!sts.tick_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ:   state_nxt = ST_DONE;
      ST_COL_RD: state_nxt = ST_COL_WR;
      ST_COL_WR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/ptps_dp.sv =====
module ptps_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptps_pkg::cmd_t                  cmd,
  output ptps_pkg::sts_t                  sts,
  input  ptps_pkg::in_item_t              in_data,
  input  logic                            cfg_we,
  input  logic [ptps_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [ptps_pkg::CFG_DW-1:0]     cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ptps_pkg::out_item_t             out_data
);
  import ptps_pkg::*;

  localparam logic signed [33:0] S_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S_MIN = 34'sh3_8000_0000;
  localparam logic [27:0]        RECIP80 = 28'd13108;
  localparam logic [14:0]        DIV80   = 15'd80;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // x / 80 for x below 2^14 by reciprocal with one correction
  function automatic logic [7:0] div80(input logic [13:0] x);
    logic [27:0] p;
    logic [7:0]  q;
    logic [14:0] qm;
    p  = 28'(x) * RECIP80;
    q  = p[27:20];
    qm = 15'(q) * DIV80;
    if (qm > 15'(x)) q = q - 8'd1;
    return q;
  endfunction

  logic [15:0] gravity_r, drag_r, bounce_r, alpha_life_r;
  logic [7:0]  alpha_step_r;

  in_item_t item_r;
  slot_t    mem [SLOT_COUNT];
  slot_t    rd_r;
  logic     v1_r, t1_r;
  logic [SLOT_AW-1:0] a1_r;
  logic [SLOT_AW-1:0] rd_addr;

  logic               found_r;
  logic [SLOT_AW-1:0] found_slot_r;
  logic [CNT_W-1:0]   live_r;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               in_range;

  // tick stage two
  logic               t2_r, v2_r;
  logic [SLOT_AW-1:0] a2_r;
  logic signed [31:0] px2_r, py2_r, pz2_r, vy2_r;
  logic signed [48:0] prx2_r, pry2_r, prz2_r;
  logic [28:0]        fy2_r;
  logic [30:0]        ht2_r;
  logic [15:0]        life2_r, lm1_2_r;
  logic [13:0]        rp2_r, gp2_r, bp2_r;
  logic [31:0]        col2_r;
  logic [15:0]        lm1;

  // tick stage three
  logic               le;
  logic signed [32:0] bnc;
  logic signed [31:0] vyb, vyn;
  logic               free3;
  logic [31:0]        col3;
  slot_t              wb3;

  logic   we;
  logic [SLOT_AW-1:0] waddr;
  slot_t  wdata;
  logic   hit;

  assign in_range = (int'(item_r.slot_index) < SLOT_COUNT);
  assign rd_addr  = cmd.rd_item ? SLOT_AW'(item_r.slot_index) : cmd.addr;
  assign hit      = v1_r && (cmd.mode == MODE_SPAWN) && !rd_r.alive;
  assign lm1      = rd_r.life - 16'd1;

  assign sts.spawn_hit = hit;
  assign sts.rd_pend   = v1_r;
  assign sts.tick_busy = t1_r | t2_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= 16'd16384;
      drag_r       <= 16'd64553;
      bounce_r     <= 16'd49152;
      alpha_life_r <= 16'd20;
      alpha_step_r <= 8'd13;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY:    gravity_r    <= cfg_data;
        CFG_DRAG:       drag_r       <= cfg_data;
        CFG_BOUNCE:     bounce_r     <= cfg_data;
        CFG_ALPHA_LIFE: alpha_life_r <= cfg_data;
        CFG_ALPHA_STEP: alpha_step_r <= cfg_data[7:0];
        default:        alpha_step_r <= alpha_step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_data;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      t1_r <= 1'b0;
      t2_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      t1_r <= cmd.rd_en && (cmd.mode == MODE_TICK);
      t2_r <= t1_r;
      v2_r <= t1_r && rd_r.alive;
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= rd_addr;
    a2_r    <= a1_r;
    px2_r   <= sat32({{2{rd_r.px[31]}}, rd_r.px} + {{2{rd_r.vx[31]}}, rd_r.vx});
    py2_r   <= sat32({{2{rd_r.py[31]}}, rd_r.py} + {{2{rd_r.vy[31]}}, rd_r.vy});
    pz2_r   <= sat32({{2{rd_r.pz[31]}}, rd_r.pz} + {{2{rd_r.vz[31]}}, rd_r.vz});
    vy2_r   <= rd_r.vy;
    prx2_r  <= rd_r.vx * $signed({1'b0, drag_r});
    prz2_r  <= rd_r.vz * $signed({1'b0, drag_r});
    pry2_r  <= rd_r.vy * $signed({1'b0, bounce_r});
    fy2_r   <= rd_r.height[30:2];
    ht2_r   <= rd_r.height;
    life2_r <= rd_r.life;
    lm1_2_r <= lm1;
    rp2_r   <= 14'(RED_FULL) * 14'(lm1[6:0]);
    gp2_r   <= 14'(GREEN_FULL) * 14'(lm1[6:0]);
    bp2_r   <= 14'(BLUE_FULL) * 14'(lm1[6:0]);
    col2_r  <= rd_r.color;
  end

  always_comb begin
    le    = $signed({py2_r[31], py2_r}) <= $signed({4'b0, fy2_r});
    bnc   = pry2_r[48:16];
    vyb   = le ? sat32(-{bnc[32], bnc}) : vy2_r;
    vyn   = sat32({{2{vyb[31]}}, vyb} - $signed({18'b0, gravity_r}));
    free3 = (life2_r <= 16'd1);
    col3  = col2_r;
    if (lm1_2_r <= FADE_LIFE) begin
      col3[31:24] = div80(rp2_r);
      col3[23:16] = div80(gp2_r);
      col3[15:8]  = div80(bp2_r);
    end
    if (lm1_2_r <= alpha_life_r) begin
      col3[7:0] = (col3[7:0] > alpha_step_r) ? col3[7:0] - alpha_step_r : 8'd0;
    end
    wb3.alive  = !free3;
    wb3.life   = free3 ? 16'd0 : lm1_2_r;
    wb3.height = ht2_r;
    // an expiring particle keeps its colour
    wb3.color  = free3 ? col2_r : col3;
    wb3.vz     = prz2_r[47:16];
    wb3.vy     = vyn;
    wb3.vx     = prx2_r[47:16];
    wb3.pz     = pz2_r;
    wb3.py     = le ? $signed({3'b0, fy2_r}) : py2_r;
    wb3.px     = px2_r;
  end

  // single write port, one user at a time
  always_comb begin
    we    = 1'b0;
    waddr = cmd.addr;
    wdata = '0;
    if (cmd.clr_en) begin
      we = 1'b1;
    end else if (v2_r) begin
      we    = 1'b1;
      waddr = a2_r;
      wdata = wb3;
    end else if (hit) begin
      we           = 1'b1;
      waddr        = a1_r;
      wdata.alive  = 1'b1;
      wdata.life   = item_r.life_ticks;
      wdata.height = item_r.height_size;
      wdata.color  = item_r.color_rgba;
      wdata.vz     = item_r.vel_z;
      wdata.vy     = item_r.vel_y;
      wdata.vx     = item_r.vel_x;
      wdata.pz     = item_r.pos_z;
      wdata.py     = item_r.pos_y;
      wdata.px     = item_r.pos_x;
    end else if (cmd.col_wr && in_range) begin
      we          = 1'b1;
      waddr       = SLOT_AW'(item_r.slot_index);
      wdata       = rd_r;
      wdata.color = item_r.color_rgba;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.take) found_r <= 1'b0;
      else if (hit) found_r <= 1'b1;
      if (hit) live_r <= live_r + 1'b1;
      else if (v2_r && free3 && live_r != '0) live_r <= live_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) found_slot_r <= a1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r            <= '0;
      out_r.live_count <= 10'(live_r);
      case (item_r.func)
        FUNC_SPAWN: begin
          out_r.status      <= !found_r;
          out_r.result_slot <= found_r ? 9'(found_slot_r) : 9'd0;
        end
        FUNC_TICK: out_r.result_slot <= 9'd0;
        FUNC_SET_COLOR: out_r.result_slot <= item_r.slot_index;
        default: begin
          out_r.result_slot <= item_r.slot_index;
          if (in_range) begin
            out_r.slot_alive <= rd_r.alive;
            out_r.out_pos_x  <= rd_r.px;
            out_r.out_pos_y  <= rd_r.py;
            out_r.out_pos_z  <= rd_r.pz;
            out_r.out_color  <= rd_r.color;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/particle_table_physics_step.sv =====
// spawn scans the slots from slot 0 and stops at the first free slot, or after every slot
//   when the table is full; tick reads one slot per cycle through a three-stage update
//   pipeline, bound by the single table read port; set colour and read each access one
//   slot; every request ends in the result register
// throughput: one request at a time; the next request is taken once the result is registered
// reset: synchronous, active low; afterwards a clearing pass marks every slot free,
//   requests are held off during it while configuration writes are taken
module particle_table_physics_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ptps_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ptps_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [ptps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ptps_pkg::CFG_DW-1:0] cfg_data
);
  import ptps_pkg::*;

  // command and status between sequencer and slot datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, slot scans for spawn and tick, single-slot access
  ptps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: particle table memory, tick pipeline, config, result register
  ptps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
